// ===== rtl/pgr_pkg.sv =====
// ----------------------------------------------------------------------------
// pgr_pkg
// shared widths, register indexes and the fixed colour palette of the ramp
// ----------------------------------------------------------------------------
`default_nettype none

package pgr_pkg;

  localparam int CNT_W               = 16;
  localparam int CH_W                = 8;
  localparam int CHANNELS            = 3;
  localparam int COLOUR_W            = CH_W * CHANNELS;
  localparam int PAL_IDX_W           = 6;
  localparam int TABLE_SIZE          = 11;
  localparam int TBL_IDX_W           = $clog2(TABLE_SIZE);
  localparam int PALETTE_ENTRIES_DEF = 11;
  localparam int CFG_IDX_W           = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [COLOUR_W-1:0]  colour_t;
  typedef logic [CNT_W-1:0]     count_t;

  localparam cfg_idx_t REG_LOW_BOUND  = 2'd0;
  localparam cfg_idx_t REG_HIGH_BOUND = 2'd1;

  localparam count_t LOW_BOUND_RST  = 16'd0;
  localparam count_t HIGH_BOUND_RST = 16'd255;

  localparam colour_t PALETTE [TABLE_SIZE] = '{
    24'h6d84a1, 24'h7e789c, 24'h898cae, 24'h77999f, 24'h8dad95, 24'ha0bb9d,
    24'hbec59c, 24'hdb9d74, 24'hbc6c5e, 24'ha35c67, 24'h6d84a1
  };

  // entries past the stored table repeat the last colour
  function automatic colour_t palette_entry(input logic [PAL_IDX_W-1:0] idx);
    colour_t c;
    if (idx >= PAL_IDX_W'(TABLE_SIZE)) begin
      c = PALETTE[TABLE_SIZE-1];
    end else begin
      c = PALETTE[idx[TBL_IDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pgr_if.sv =====
// ----------------------------------------------------------------------------
// pgr_if
// valid/ready channels of the gradient ramp: count in, colour out, config
// ----------------------------------------------------------------------------
`default_nettype none

interface pgr_in_if;
  logic                      valid;
  logic                      ready;
  logic [pgr_pkg::CNT_W-1:0] iteration_count;
  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

interface pgr_out_if;
  logic                         valid;
  logic                         ready;
  logic [pgr_pkg::COLOUR_W-1:0] pixel_colour;
  logic                         range_error;
  modport source (output valid, output pixel_colour, output range_error, input ready);
  modport sink   (input valid, input pixel_colour, input range_error, output ready);
endinterface

interface pgr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pgr_pkg::CFG_IDX_W-1:0] index;
  logic [pgr_pkg::CNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pgr_div_cell.sv =====
// ----------------------------------------------------------------------------
// pgr_div_cell
// one restoring division step per lane; quotient bit shifts into the dividend
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_div_cell #(
  parameter int LANES  = 1,
  parameter int DVD_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic [pgr_pkg::CNT_W-1:0]             range,
  input  logic                                  in_valid,
  input  logic [LANES-1:0][pgr_pkg::CNT_W-1:0]  in_rem,
  input  logic [LANES-1:0][DVD_W-1:0]           in_dvd,
  input  logic [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  output logic [LANES-1:0][pgr_pkg::CNT_W-1:0]  out_rem,
  output logic [LANES-1:0][DVD_W-1:0]           out_dvd,
  output logic [SIDE_W-1:0]                     out_side
);

  logic                                 valid_r;
  logic [LANES-1:0][pgr_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][DVD_W-1:0]          dvd_r, dvd_nxt;
  logic [SIDE_W-1:0]                    side_r;

  always_comb begin
    logic [pgr_pkg::CNT_W:0] shifted;
    logic [pgr_pkg::CNT_W:0] diff;
    logic                    ge;
    for (int l = 0; l < LANES; l++) begin
      shifted    = {in_rem[l], in_dvd[l][DVD_W-1]};
      diff       = shifted - {1'b0, range};
      ge         = (shifted >= {1'b0, range});
      rem_nxt[l] = ge ? diff[pgr_pkg::CNT_W-1:0] : shifted[pgr_pkg::CNT_W-1:0];
      dvd_nxt[l] = (in_dvd[l] << 1) | DVD_W'(ge);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      dvd_r  <= dvd_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dvd   = dvd_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// ===== rtl/pgr_div_chain.sv =====
// ----------------------------------------------------------------------------
// pgr_div_chain
// row of division cells, one quotient bit per cell, DVD_W cells long
// ----------------------------------------------------------------------------
`default_nettype none

module pgr_div_chain #(
  parameter int LANES  = 1,
  parameter int DVD_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic [pgr_pkg::CNT_W-1:0]             range,
  input  logic                                  in_valid,
  input  logic [LANES-1:0][pgr_pkg::CNT_W-1:0]  in_rem,
  input  logic [LANES-1:0][DVD_W-1:0]           in_dvd,
  input  logic [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  output logic [LANES-1:0][pgr_pkg::CNT_W-1:0]  out_rem,
  output logic [LANES-1:0][DVD_W-1:0]           out_dvd,
  output logic [SIDE_W-1:0]                     out_side
);

  logic [DVD_W:0]                                 v_c;
  logic [DVD_W:0][LANES-1:0][pgr_pkg::CNT_W-1:0]  rem_c;
  logic [DVD_W:0][LANES-1:0][DVD_W-1:0]           dvd_c;
  logic [DVD_W:0][SIDE_W-1:0]                     side_c;

  assign v_c[0]    = in_valid;
  assign rem_c[0]  = in_rem;
  assign dvd_c[0]  = in_dvd;
  assign side_c[0] = in_side;

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    pgr_div_cell #(
      .LANES  (LANES),
      .DVD_W  (DVD_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .range     (range),
      .in_valid  (v_c[i]),
      .in_rem    (rem_c[i]),
      .in_dvd    (dvd_c[i]),
      .in_side   (side_c[i]),
      .out_valid (v_c[i+1]),
      .out_rem   (rem_c[i+1]),
      .out_dvd   (dvd_c[i+1]),
      .out_side  (side_c[i+1])
    );
  end

  assign out_valid = v_c[DVD_W];
  assign out_rem   = rem_c[DVD_W];
  assign out_dvd   = dvd_c[DVD_W];
  assign out_side  = side_c[DVD_W];

endmodule

`default_nettype wire

// ===== rtl/palette_gradient_ramp.sv =====
// ----------------------------------------------------------------------------
// palette_gradient_ramp
// maps an escape iteration count to a 24-bit colour on a repeating gradient
// ----------------------------------------------------------------------------
//  channel   dir  payload                         request taken when
//  in_chan   in   iteration_count[15:0]           valid && ready
//  out_chan  out  pixel_colour[23:0], range_error valid && ready
//  cfg_chan  in   index[1:0], data[15:0]          valid && ready (ready tied high)
//
//  one request per cycle while no result is stalled at the output
//  the three restoring divider rows hold 16 cells for the position
//  modulo, clog2(PALETTE_ENTRIES) cells for the segment, 8 cells for the blend
//  rst_n is synchronous, active low; clears valid bits and the bound registers
//  a stalled result freezes the whole pipeline; in_chan.ready drops only then
// ----------------------------------------------------------------------------
`default_nettype none

module palette_gradient_ramp #(
  parameter int PALETTE_ENTRIES = pgr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pgr_in_if.sink    in_chan,
  pgr_out_if.source out_chan,
  pgr_cfg_if.sink   cfg_chan
);

  localparam int CNT_W    = pgr_pkg::CNT_W;
  localparam int CH_W     = pgr_pkg::CH_W;
  localparam int CHANNELS = pgr_pkg::CHANNELS;
  localparam int COLOUR_W = pgr_pkg::COLOUR_W;
  localparam int SEG_W    = $clog2(PALETTE_ENTRIES);
  localparam int Q_W      = CNT_W + SEG_W;
  localparam int NUM_W    = CH_W + CNT_W;
  localparam logic [SEG_W-1:0] SEG_SPAN = SEG_W'(PALETTE_ENTRIES - 1);

  // configuration: bounds plus the period kept ready for the dividers
  pgr_pkg::count_t low_r, high_r, range_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= pgr_pkg::LOW_BOUND_RST;
      high_r  <= pgr_pkg::HIGH_BOUND_RST;
      range_r <= pgr_pkg::HIGH_BOUND_RST - pgr_pkg::LOW_BOUND_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        pgr_pkg::REG_LOW_BOUND: begin
          low_r   <= cfg_chan.data;
          range_r <= high_r - cfg_chan.data;
        end
        pgr_pkg::REG_HIGH_BOUND: begin
          high_r  <= cfg_chan.data;
          range_r <= cfg_chan.data - low_r;
        end
        default: begin
        end
      endcase
    end
  end

  // whole pipeline moves unless a finished result is waiting
  logic en;
  logic out_valid_r;
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 0: distance from low bound, with its sign
  logic [CNT_W:0]   diff0;
  logic             s0_valid_r, s0_neg_r, s0_err_r;
  logic [CNT_W-1:0] s0_dist_r;

  assign diff0 = {1'b0, in_chan.iteration_count} - {1'b0, low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_neg_r  <= diff0[CNT_W];
      s0_dist_r <= diff0[CNT_W] ? (low_r - in_chan.iteration_count) : diff0[CNT_W-1:0];
      s0_err_r  <= (range_r == '0);
    end
  end

  // divider row a: |distance| mod range
  logic                    a_valid;
  logic [0:0][CNT_W-1:0]   a_rem;
  logic [1:0]              a_side;

  pgr_div_chain #(
    .LANES  (1),
    .DVD_W  (CNT_W),
    .SIDE_W (2)
  ) u_mod_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .range     (range_r),
    .in_valid  (s0_valid_r),
    .in_rem    ('0),
    .in_dvd    (s0_dist_r),
    .in_side   ({s0_neg_r, s0_err_r}),
    .out_valid (a_valid),
    .out_rem   (a_rem),
    .out_dvd   (),
    .out_side  (a_side)
  );

  // stage 1: floored position, scaled by the segment count
  logic [CNT_W-1:0] pos1;
  logic             s1_valid_r, s1_err_r;
  logic [Q_W-1:0]   s1_q_r;

  // a negative distance folds back from the top of the period
  assign pos1 = (a_side[1] && (a_rem[0] != '0)) ? (range_r - a_rem[0]) : a_rem[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q_r   <= Q_W'(pos1) * Q_W'(SEG_SPAN);
      s1_err_r <= a_side[0];
    end
  end

  // divider row b: segment index and fraction numerator
  // q < range * 2^SEG_W, so the top bits already sit below range
  logic                  b_valid;
  logic [0:0][CNT_W-1:0] b_rem;
  logic [0:0][SEG_W-1:0] b_seg;
  logic                  b_err;

  pgr_div_chain #(
    .LANES  (1),
    .DVD_W  (SEG_W),
    .SIDE_W (1)
  ) u_seg_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .range     (range_r),
    .in_valid  (s1_valid_r),
    .in_rem    (s1_q_r[Q_W-1:SEG_W]),
    .in_dvd    (s1_q_r[SEG_W-1:0]),
    .in_side   (s1_err_r),
    .out_valid (b_valid),
    .out_rem   (b_rem),
    .out_dvd   (b_seg),
    .out_side  (b_err)
  );

  // stage 2: palette lookup of both segment ends
  logic                       s2_valid_r, s2_err_r;
  pgr_pkg::colour_t           s2_ca_r, s2_cb_r;
  logic [CNT_W-1:0]           s2_frac_r;
  logic [pgr_pkg::PAL_IDX_W-1:0] seg_idx;

  assign seg_idx = pgr_pkg::PAL_IDX_W'(b_seg[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ca_r   <= pgr_pkg::palette_entry(seg_idx);
      s2_cb_r   <= pgr_pkg::palette_entry(seg_idx + pgr_pkg::PAL_IDX_W'(1));
      s2_frac_r <= b_rem[0];
      s2_err_r  <= b_err;
    end
  end

  // stage 3: weighted sum per channel, a*(range-r) + b*r
  logic [CNT_W-1:0]                 w_lo;
  logic [CHANNELS-1:0][NUM_W-1:0]   num3;
  logic                             s3_valid_r, s3_err_r;
  logic [CHANNELS-1:0][NUM_W-1:0]   s3_num_r;
  logic [CHANNELS-1:0][CNT_W-1:0]   s3_hi;
  logic [CHANNELS-1:0][CH_W-1:0]    s3_lo;

  assign w_lo = range_r - s2_frac_r;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      // channel 0 is red in the top byte
      num3[c] = NUM_W'(s2_ca_r[COLOUR_W-1-c*CH_W -: CH_W]) * NUM_W'(w_lo)
              + NUM_W'(s2_cb_r[COLOUR_W-1-c*CH_W -: CH_W]) * NUM_W'(s2_frac_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_r <= num3;
      s3_err_r <= s2_err_r;
    end
  end

  // blend result never exceeds 255, so num >> 8 starts below range
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      s3_hi[c] = s3_num_r[c][NUM_W-1:CH_W];
      s3_lo[c] = s3_num_r[c][CH_W-1:0];
    end
  end

  // divider row c: three channel lanes in lockstep
  logic                          c_valid;
  logic [CHANNELS-1:0][CH_W-1:0] c_quo;
  logic                          c_err;

  pgr_div_chain #(
    .LANES  (CHANNELS),
    .DVD_W  (CH_W),
    .SIDE_W (1)
  ) u_blend_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .range     (range_r),
    .in_valid  (s3_valid_r),
    .in_rem    (s3_hi),
    .in_dvd    (s3_lo),
    .in_side   (s3_err_r),
    .out_valid (c_valid),
    .out_rem   (),
    .out_dvd   (c_quo),
    .out_side  (c_err)
  );

  // output register: zero range forces black
  pgr_pkg::colour_t colour_nxt;
  pgr_pkg::colour_t out_colour_r;
  logic             out_err_r;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      colour_nxt[COLOUR_W-1-c*CH_W -: CH_W] = c_err ? '0 : c_quo[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_colour_r <= colour_nxt;
      out_err_r    <= c_err;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_colour = out_colour_r;
  assign out_chan.range_error  = out_err_r;

`ifndef SYNTHESIS
  // input side only backs off behind an untaken result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without a pending result");

  // a result only appears after the blend row delivered one
  a_out_from_blend_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(c_valid))
    else $error("result valid without blend row output");

  // a frozen pipeline keeps its head stage and its pending result
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!en && rst_n) |-> ($stable(s0_dist_r) && out_chan.valid))
    else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire
